// File: rtl/core/iol_pkg.sv
package iol_pkg;

	localparam int unsigned CAPACITY_DEF  = 64;
	localparam int unsigned DATA_BITS_DEF = 32;

	typedef enum logic [3:0] {
		K_INS_FRONT = 4'd0,
		K_INS_BACK  = 4'd1,
		K_INS_AT    = 4'd2,
		K_REM_FRONT = 4'd3,
		K_REM_BACK  = 4'd4,
		K_REM_AT    = 4'd5,
		K_SEARCH    = 4'd6,
		K_SELECT    = 4'd7,
		K_REPLACE   = 4'd8
	} kind_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INS,
		OP_REM,
		OP_SEARCH,
		OP_SELECT,
		OP_REPLACE
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

// File: rtl/core/indexed_ordered_list.sv
// Sequencing: ops with no memory pass step from accept to finish, then output;
//   otherwise (insert/remove shift, search scan, select) through read, drain, finish
//   and output, a search hit skipping drain. One transaction at a time; the next input
//   is taken after the result is accepted, so the longest item is a search of a full list,
//   set by the element memory (one read, one write port) walked one entry per cycle.
// Reset: arst_n low clears count and sequencer; element memory is not cleared.
module indexed_ordered_list #(
	parameter int unsigned CAPACITY  = iol_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_BITS = iol_pkg::DATA_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         kind,
	input  logic [6:0]         position,
	input  logic signed [31:0] item_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic signed [31:0] read_value,
	output logic [6:0]         found_index,
	output logic [6:0]         count,
	output logic               is_empty,
	output logic               is_full
);
	import iol_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [DATA_BITS-1:0] mem [CAPACITY];

	state_t               state_q, state_d;
	op_t                  op_q;
	logic                 res_ok_q;
	logic [AW-1:0]        at_q;
	logic [DATA_BITS-1:0] val_q;
	logic [AW-1:0]        ptr_q;
	logic [AW-1:0]        last_q;
	logic                 up_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        fidx_q;
	logic [31:0]          rdval_q;
	logic [DATA_BITS-1:0] rdata_q;
	logic                 rv_s1;
	logic [AW-1:0]        raddr_s1;

	// decode
	op_t                  dec_op;
	logic                 dec_ok;
	logic                 dec_reads;
	logic                 dec_up;
	logic [XW-1:0]        dec_at;
	logic [XW-1:0]        dec_first;
	logic [XW-1:0]        dec_last;
	logic [XW-1:0]        pos_x;
	logic [XW-1:0]        cnt_x;
	logic [63:0]          val64;
	logic [DATA_BITS-1:0] val_in;

	logic                 rd_en;
	logic                 hit;
	logic                 we;
	logic [AW-1:0]        wa;
	logic [DATA_BITS-1:0] wd;
	logic signed [DATA_BITS-1:0] rdata_sg;
	logic [63:0]          rd64;

	assign pos_x    = XW'(position);
	assign cnt_x    = XW'(cnt_q);
	assign val64    = 64'(item_value);
	assign val_in   = val64[DATA_BITS-1:0];
	assign rdata_sg = rdata_q;
	assign rd64     = 64'(rdata_sg);

	always_comb begin
		dec_op    = OP_NONE;
		dec_ok    = 1'b0;
		dec_reads = 1'b0;
		dec_up    = 1'b1;
		dec_at    = '0;
		dec_first = '0;
		dec_last  = '0;
		unique case (kind)
			K_INS_FRONT, K_INS_BACK, K_INS_AT: begin
				dec_op = OP_INS;
				unique case (kind)
					K_INS_FRONT: dec_at = '0;
					K_INS_BACK:  dec_at = cnt_x;
					default:     dec_at = pos_x;
				endcase
				dec_ok    = (cnt_q != CAP_C) && (dec_at <= cnt_x);
				dec_reads = dec_ok && (dec_at < cnt_x);
				dec_up    = 1'b0;
				dec_first = cnt_x - XW'(1);
				dec_last  = dec_at;
			end
			K_REM_FRONT, K_REM_BACK, K_REM_AT: begin
				dec_op = OP_REM;
				unique case (kind)
					K_REM_FRONT: dec_at = '0;
					K_REM_BACK:  dec_at = cnt_x - XW'(1);
					default:     dec_at = pos_x;
				endcase
				dec_ok    = (cnt_q != '0) && (dec_at < cnt_x);
				dec_reads = dec_ok && ((dec_at + XW'(1)) < cnt_x);
				dec_first = dec_at + XW'(1);
				dec_last  = cnt_x - XW'(1);
			end
			K_SEARCH: begin
				dec_op    = OP_SEARCH;
				dec_reads = (cnt_q != '0);
				dec_last  = cnt_x - XW'(1);
			end
			K_SELECT: begin
				dec_op    = OP_SELECT;
				dec_ok    = pos_x < cnt_x;
				dec_reads = (cnt_q != '0);
				dec_first = dec_ok ? pos_x : (cnt_x - XW'(1));
				dec_last  = dec_first;
			end
			K_REPLACE: begin
				dec_op = OP_REPLACE;
				dec_ok = pos_x < cnt_x;
				dec_at = pos_x;
			end
			default: dec_op = OP_NONE;
		endcase
	end

	assign hit   = rv_s1 && (op_q == OP_SEARCH) && (rdata_q == val_q);
	assign rd_en = (state_q == ST_READ) && !hit;

	always_comb begin
		we = 1'b0;
		wa = at_q;
		wd = val_q;
		if ((state_q == ST_READ || state_q == ST_DRAIN) && rv_s1) begin
			if (op_q == OP_INS) begin
				we = 1'b1;
				wa = raddr_s1 + AW'(1);
				wd = rdata_q;
			end else if (op_q == OP_REM) begin
				we = 1'b1;
				wa = raddr_s1 - AW'(1);
				wd = rdata_q;
			end
		end else if (state_q == ST_FIN && res_ok_q &&
				(op_q == OP_INS || op_q == OP_REPLACE)) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= rd_en;
			if (state_q == ST_FIN && res_ok_q) begin
				if (op_q == OP_INS) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (op_q == OP_REM) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			raddr_s1 <= ptr_q;
			ptr_q    <= up_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
		end
		if (state_q == ST_IDLE && in_valid) begin
			op_q     <= dec_op;
			res_ok_q <= dec_ok;
			at_q     <= AW'(dec_at);
			ptr_q    <= AW'(dec_first);
			last_q   <= AW'(dec_last);
			up_q     <= dec_up;
			val_q    <= val_in;
			fidx_q   <= (dec_op == OP_SEARCH) ? cnt_q : '0;
			rdval_q  <= '0;
		end
		if (hit) begin
			res_ok_q <= 1'b1;
			fidx_q   <= CW'(raddr_s1);
		end
		if (state_q == ST_DRAIN && rv_s1 && op_q == OP_SELECT) begin
			rdval_q <= rd64[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = dec_reads ? ST_READ : ST_FIN;
				end
			end
			ST_READ: begin
				if (hit) begin
					state_d = ST_FIN;
				end else if (ptr_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign ok          = res_ok_q;
	assign read_value  = rdval_q;
	assign found_index = 7'(fidx_q);
	assign count       = 7'(cnt_q);
	assign is_empty    = (cnt_q == '0);
	assign is_full     = (cnt_q == CAP_C);

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("count above capacity");

	a_cnt_only_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIN) |=> $stable(cnt_q))
		else $error("count changed outside finish step");

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (CW'(wa) < CAP_C))
		else $error("memory write out of range");

	a_read_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (state_q == ST_READ || state_q == ST_DRAIN || state_q == ST_FIN))
		else $error("read data returned in wrong state");
`endif

endmodule
